@@ src/guid_text_parser_core_macros.svh @@
// Assertion macros for the identifier text parser.
// Included by the top level only; no other dependencies.
`ifndef GUID_TEXT_PARSER_CORE_MACROS_SVH
`define GUID_TEXT_PARSER_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define GTP_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define GTP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/gtp_pkg.sv @@
// Shared types and constants for the identifier text parser.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package gtp_pkg;

   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_DASH  = 8'h2D;
   localparam logic [7:0] CH_BRACE = 8'h7B;

   localparam logic [4:0] ID_BYTES = 5'd16;
   localparam int         ID_BITS  = 128;

   // parse phases
   localparam logic [2:0] PH_LEAD   = 3'd0;
   localparam logic [2:0] PH_BRACE  = 3'd1;
   localparam logic [2:0] PH_SP2    = 3'd2;
   localparam logic [2:0] PH_SECOND = 3'd3;
   localparam logic [2:0] PH_SEP1   = 3'd4;
   localparam logic [2:0] PH_DASH   = 3'd5;
   localparam logic [2:0] PH_SEP3   = 3'd6;
   localparam logic [2:0] PH_DONE   = 3'd7;

   typedef struct packed {
      logic       is_hex;
      logic [3:0] nibble;
      logic       is_space;
      logic       is_dash;
      logic       is_brace;
   } char_class_type;

   typedef struct packed {
      logic [2:0]         phase;
      logic [4:0]         byte_count;
      logic [3:0]         high_nibble;
      logic [ID_BITS-1:0] id;
      logic               failed;
   } parse_state_type;

   typedef struct packed {
      logic               ok;
      logic [ID_BITS-1:0] id;
   } parse_result_type;

   localparam parse_state_type PARSE_RESET = '{
      phase:       PH_LEAD,
      byte_count:  5'd0,
      high_nibble: 4'd0,
      id:          '0,
      failed:      1'b0
   };

endpackage

@@ src/gtp_char_decode.sv @@
// Character classifier: hex digit value and separator flags for one byte.
// Depends on gtp_pkg.
`timescale 1ns / 1ps

module gtp_char_decode
   import gtp_pkg::*;
(
   input  logic [7:0]     ch,
   output char_class_type cls
);

   always_comb begin
      cls = '0;
      if (ch inside {[8'h30:8'h39]}) begin
         cls.is_hex = 1'b1;
         cls.nibble = ch[3:0];
      end else if (ch inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
         // 'A'/'a' have low nibble 1, so add nine
         cls.is_hex = 1'b1;
         cls.nibble = ch[3:0] + 4'd9;
      end
      cls.is_space = (ch == CH_SPACE);
      cls.is_dash  = (ch == CH_DASH);
      cls.is_brace = (ch == CH_BRACE);
   end

endmodule

@@ src/gtp_parse_step.sv @@
// Next-state logic of the parser: one character against the current state.
// Depends on gtp_pkg; fed by gtp_char_decode.
`timescale 1ns / 1ps

module gtp_parse_step
   import gtp_pkg::*;
(
   input  parse_state_type  cur,
   input  char_class_type   cls,
   input  logic             last,
   output parse_state_type  nxt,
   output parse_result_type result
);

   logic       start;
   logic       push;
   logic [7:0] push_byte;
   logic       fin;
   logic       push_any;
   logic [7:0] shift_byte;
   logic       final_byte;

   always_comb begin
      nxt        = cur;
      start      = 1'b0;
      push       = 1'b0;
      push_byte  = 8'd0;
      final_byte = (cur.byte_count == ID_BYTES - 5'd1);

      if (!cur.failed) begin
         case (cur.phase)
            PH_LEAD: begin
               if (cls.is_brace) nxt.phase = PH_BRACE;
               else if (!cls.is_space) start = 1'b1;
            end
            PH_BRACE: begin
               if (cls.is_space) nxt.phase = PH_SP2;
               else if (!cls.is_brace) start = 1'b1;
            end
            PH_SP2: begin
               if (!cls.is_space) start = 1'b1;
            end
            PH_SECOND: begin
               push = 1'b1;
               if (cls.is_hex) begin
                  push_byte = {cur.high_nibble, cls.nibble};
                  nxt.phase = final_byte ? PH_DONE : PH_SEP1;
               end else begin
                  // lone digit: close the byte, then treat char as separator
                  push_byte = {4'd0, cur.high_nibble};
                  if (final_byte) nxt.phase = PH_DONE;
                  else if (cls.is_dash) nxt.phase = PH_DASH;
                  else begin
                     nxt.phase = PH_SEP1;
                     if (!cls.is_space) start = 1'b1;
                  end
               end
            end
            PH_SEP1: begin
               if (cls.is_dash) nxt.phase = PH_DASH;
               else if (!cls.is_space) start = 1'b1;
            end
            PH_DASH: begin
               if (cls.is_space) nxt.phase = PH_SEP3;
               else if (!cls.is_dash) start = 1'b1;
            end
            PH_SEP3: begin
               if (!cls.is_space) start = 1'b1;
            end
            default: begin
            end
         endcase
      end

      if (start) begin
         if (cls.is_hex) begin
            nxt.high_nibble = cls.nibble;
            nxt.phase       = PH_SECOND;
         end else begin
            nxt.failed = 1'b1;
         end
      end

      // a pending lone digit on the final character completes a byte
      fin        = last && !nxt.failed && (nxt.phase == PH_SECOND);
      push_any   = push || fin;
      shift_byte = fin ? {4'd0, nxt.high_nibble} : push_byte;

      if (push_any) begin
         nxt.id         = {cur.id[ID_BITS-9:0], shift_byte};
         nxt.byte_count = cur.byte_count + 5'd1;
      end

      result.ok = !nxt.failed && (nxt.byte_count >= ID_BYTES);
      result.id = result.ok ? nxt.id : '0;
   end

endmodule

@@ src/guid_text_parser_core.sv @@
// Top level of the identifier text parser: state register, result register.
// Depends on gtp_pkg, gtp_char_decode, gtp_parse_step and the macro header.
`timescale 1ns / 1ps
`include "guid_text_parser_core_macros.svh"

// Parses a 128-bit identifier from text, one ASCII character per word on the
// req_ channel. Leading spaces, then any '{' run, then spaces are skipped;
// sixteen bytes of one or two hex digits follow, separated by optional
// spaces, dashes and spaces. Anything after the sixteenth byte is ignored.
// The word marked req_last produces exactly one rsp_ word: rsp_ok high with
// the identifier (byte 0 at the top of rsp_id_high), or rsp_ok low with both
// id fields zero. The parser then starts over on the next character.
// Rate: one character per clock, sustained. The single loop through the
// parse state register is the only recurrence; the registered result
// appears in the cycle after the last character is taken. Only a last
// character can be held off, and only while a prior result stalls on rsp_.
module guid_text_parser_core
   import gtp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // character input
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_ch,
   input  logic        req_last,
   // parse result
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_ok,
   output logic [63:0] rsp_id_high,
   output logic [63:0] rsp_id_low
);

   parse_state_type  state_ff;
   parse_state_type  state_in;
   parse_state_type  step_nxt;
   parse_result_type step_res;
   char_class_type   char_cls;

   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   logic        rsp_ok_ff;
   logic [63:0] rsp_id_high_ff;
   logic [63:0] rsp_id_low_ff;

   logic req_take;
   logic rsp_load;

   logic rsp_fail;
   logic fail_id_zero;
   logic restarted;
   logic done_count_agree;

   // Classify the incoming character.
   gtp_char_decode u_decode (
      .ch  (req_ch),
      .cls (char_cls)
   );

   // Advance the parse by one character.
   gtp_parse_step u_step (
      .cur    (state_ff),
      .cls    (char_cls),
      .last   (req_last),
      .nxt    (step_nxt),
      .result (step_res)
   );

   // Hold off only a last word, and only when the result register is
   // occupied and its consumer is stalling; other words always pass.
   assign req_stall = rsp_valid_ff & rsp_stall & req_last;
   assign req_take  = req_valid & ~req_stall;
   assign rsp_load  = req_take & req_last;

   // Advance the state on every accepted word; drop back to the start of a
   // new string once the last word has been taken.
   always_comb begin
      state_in = state_ff;
      if (req_take) begin
         state_in = req_last ? PARSE_RESET : step_nxt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= PARSE_RESET;
      end else begin
         state_ff <= state_in;
      end
   end

   // Result register: load on a last word, clear once taken downstream.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) rsp_valid_in = 1'b1;
      else if (!rsp_stall) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_ok_ff      <= step_res.ok;
         rsp_id_high_ff <= step_res.id[ID_BITS-1:64];
         rsp_id_low_ff  <= step_res.id[63:0];
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_ok      = rsp_ok_ff;
   assign rsp_id_high = rsp_id_high_ff;
   assign rsp_id_low  = rsp_id_low_ff;

   // Terms checked by the assertions below.
   assign rsp_fail         = rsp_valid_ff && !rsp_ok_ff;
   assign fail_id_zero     = (rsp_id_high_ff == 64'd0) && (rsp_id_low_ff == 64'd0);
   assign restarted        = rsp_valid_ff && (state_ff.phase == PH_LEAD)
                             && (state_ff.byte_count == 5'd0);
   assign done_count_agree = ((state_ff.phase == PH_DONE) == (state_ff.byte_count == ID_BYTES))
                             && (state_ff.byte_count <= ID_BYTES);

   // A failed parse never carries identifier bits.
   `GTP_ASSERT_NOW(a_fail_zero, clock, reset, rsp_fail, fail_id_zero, "failed result has id")

   // The last word yields a result and restarts the parse.
   `GTP_ASSERT_NEXT(a_last_restart, clock, reset, rsp_load, restarted, "no restart after last")

   // The done phase is reached exactly when all sixteen bytes are in.
   `GTP_ASSERT_NOW(a_done_count, clock, reset, 1'b1, done_count_agree, "done phase disagrees")

endmodule
